>>> sv/positional_list_store_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list store
// Shared property forms used by the design's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PLSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/plsu_pkg.sv
// ----------------------------------------------------------------------------
// plsu_pkg
// Beat types, command codes and cell-chain control for the list store.
// ----------------------------------------------------------------------------
package plsu_pkg;

  localparam int LEN_W  = 5;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int CMD_W  = 3;
  // Index width for the chain; covers indices and counts up to 127.
  localparam int IDX_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AT  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_DELETE_AT  = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_DUMP       = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] fill;
  } chain_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } out_beat_t;

endpackage

>>> sv/plsu_cell.sv
// ----------------------------------------------------------------------------
// plsu_cell
// One storage slot of the chain: keeps, loads, or takes a neighbor's or the head's value.
// ----------------------------------------------------------------------------
module plsu_cell
  import plsu_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  chain_ctl_t            ctl,
  input  logic [DATA_WIDTH-1:0] ins_value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] head_data,
  output logic [DATA_WIDTH-1:0] data_out
);

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INSERT: begin
        if (IDX == ctl.pos) begin
          data_nxt = ins_value;
        end else if (IDX > ctl.pos) begin
          data_nxt = left_data;
        end
      end
      OP_DELETE: begin
        if (IDX >= ctl.pos) begin
          data_nxt = right_data;
        end
      end
      OP_ROTATE: begin
        // advance toward the head; the last live slot wraps the head around
        if (IDX + 1'b1 < ctl.fill) begin
          data_nxt = right_data;
        end else if (IDX + 1'b1 == ctl.fill) begin
          data_nxt = head_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

>>> sv/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Bounded ordered list of values with positional insert, delete and dump.
// ----------------------------------------------------------------------------
// Elements sit in a row of CAPACITY cells, slot 0 at the front. Insert and
// delete shift every later element by one place, so all commands but dump
// are taken at one per cycle while the output does not stall and answer
// with one beat. A dump streams one element per cycle from the head cell
// while the chain rotates and the output does not stall; no command is
// taken until its last beat has been loaded. Output stall holds the result
// register and, through it, the input side. Bad positions, a full list on
// insert, an empty list on delete and unknown commands answer ok = 0 and
// leave the list as it was. No clearing pass is needed after reset.
`include "positional_list_store_unit_defines.svh"

module positional_list_store_unit
  import plsu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_r, out_nxt;

  chain_ctl_t            ctl;
  logic [DATA_WIDTH-1:0] ins_value;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [63:0]           head_ext;

  logic             out_ready;
  logic             in_accept;
  logic             emit;
  logic             dump_last;
  logic             cmd_ok;
  logic             is_insert;
  logic             is_delete;
  logic             is_dump;
  logic [IDX_W-1:0] pos_ext;
  logic [IDX_W-1:0] fill_ext;
  logic [IDX_W-1:0] op_pos;
  logic             full;
  logic             empty;

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_ready;
  assign in_accept = in_valid && !in_stall;
  assign emit      = (state_r == ST_DUMP) && out_ready;
  assign dump_last = (cnt_r + 1'b1 == fill_r);

  assign pos_ext  = IDX_W'(in_data.position);
  assign fill_ext = IDX_W'(fill_r);
  assign full     = (fill_ext == IDX_W'(CAPACITY));
  assign empty    = (fill_r == '0);

  assign ins_value = DATA_WIDTH'(64'($unsigned(in_data.item_value)));
  assign head_ext  = 64'(cell_data[0]);

  // command decode
  always_comb begin
    cmd_ok    = 1'b0;
    is_insert = 1'b0;
    is_delete = 1'b0;
    is_dump   = 1'b0;
    op_pos    = '0;
    case (in_data.cmd)
      CMD_INSERT_AT: begin
        is_insert = 1'b1;
        op_pos    = pos_ext;
        cmd_ok    = !full && (pos_ext <= fill_ext);
      end
      CMD_PUSH_FRONT: begin
        is_insert = 1'b1;
        cmd_ok    = !full;
      end
      CMD_PUSH_BACK: begin
        is_insert = 1'b1;
        op_pos    = fill_ext;
        cmd_ok    = !full;
      end
      CMD_DELETE_AT: begin
        is_delete = 1'b1;
        op_pos    = pos_ext;
        cmd_ok    = (pos_ext < fill_ext);
      end
      CMD_POP_FRONT: begin
        is_delete = 1'b1;
        cmd_ok    = !empty;
      end
      CMD_POP_BACK: begin
        is_delete = 1'b1;
        op_pos    = fill_ext - 1'b1;
        cmd_ok    = !empty;
      end
      CMD_DUMP: begin
        is_dump = 1'b1;
        cmd_ok  = !empty;
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  // chain control and sequencing
  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.pos       = op_pos;
    ctl.fill      = fill_ext;
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (is_dump && cmd_ok) begin
            state_nxt = ST_DUMP;
            cnt_nxt   = '0;
          end else begin
            if (cmd_ok && is_insert) begin
              ctl.op   = OP_INSERT;
              fill_nxt = fill_r + 1'b1;
            end else if (cmd_ok && is_delete) begin
              ctl.op   = OP_DELETE;
              fill_nxt = fill_r - 1'b1;
            end
            out_valid_nxt   = 1'b1;
            out_nxt.ok      = cmd_ok;
            out_nxt.element = '0;
            out_nxt.length  = LEN_W'(fill_nxt);
            out_nxt.last    = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (emit) begin
          ctl.op          = OP_ROTATE;
          out_valid_nxt   = 1'b1;
          out_nxt.ok      = 1'b1;
          out_nxt.element = head_ext[VAL_W-1:0];
          out_nxt.length  = LEN_W'(fill_r);
          out_nxt.last    = dump_last;
          cnt_nxt         = cnt_r + 1'b1;
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plsu_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_value  (ins_value),
      .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .head_data  (cell_data[0]),
      .data_out   (cell_data[i])
    );
  end

  `PLSU_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CW'(CAPACITY),
    "element count above capacity")
  `PLSU_ASSERT_NOW(a_dump_cnt, state_r == ST_DUMP, cnt_r < fill_r,
    "dump index past the element count")
  `PLSU_ASSERT_NEXT(a_dump_fill, state_r == ST_DUMP, $stable(fill_r),
    "element count changed during dump")
  `PLSU_ASSERT_NEXT(a_single_beat, in_accept && !(is_dump && cmd_ok),
    out_valid_r && out_r.last, "single-beat command gave no final beat")

endmodule

>>> bench/list_beat_checker.sv
// ----------------------------------------------------------------------------
// list_beat_checker
// Watches both channels of the list store. It keeps its own copy of the list,
// works out the result beats of every accepted command and compares each
// accepted result beat with the oldest one still waiting.
// ----------------------------------------------------------------------------
module list_beat_checker
  import plsu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending,
  output int        cmd_count,
  output int        beat_count,
  output int        reject_count,
  output int        peak_length
);

  logic [DATA_WIDTH-1:0] contents[$];
  out_beat_t             awaited_beats[$];

  function automatic out_beat_t status_beat(logic ok);
    out_beat_t r;
    r.ok      = ok;
    r.element = '0;
    r.length  = LEN_W'(contents.size());
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic void apply_list_cmd(in_beat_t b);
    int        n;
    int        at;
    logic      ok;
    out_beat_t r;
    n  = contents.size();
    ok = 1'b0;
    at = 0;
    case (b.cmd)
      CMD_INSERT_AT, CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (b.cmd == CMD_INSERT_AT) at = b.position;
        else if (b.cmd == CMD_PUSH_BACK) at = n;
        if (n < CAPACITY && at <= n) begin
          contents.insert(at, b.item_value[DATA_WIDTH-1:0]);
          ok = 1'b1;
        end
      end
      CMD_DELETE_AT, CMD_POP_FRONT, CMD_POP_BACK: begin
        if (b.cmd == CMD_DELETE_AT) at = b.position;
        else if (b.cmd == CMD_POP_BACK) at = n - 1;
        if (n > 0 && at < n) begin
          contents.delete(at);
          ok = 1'b1;
        end
      end
      CMD_DUMP: begin
        // stream every element front to back, last mark on the final one
        for (int i = 0; i < n; i++) begin
          r.ok      = 1'b1;
          r.element = contents[i];
          r.length  = LEN_W'(n);
          r.last    = (i == n - 1);
          awaited_beats.push_back(r);
        end
        ok = (n > 0);
      end
      default: ok = 1'b0;
    endcase
    if (b.cmd != CMD_DUMP || n == 0) awaited_beats.push_back(status_beat(ok));
    if (!ok) reject_count++;
    if (contents.size() > peak_length) peak_length = contents.size();
    cmd_count++;
  endfunction

  function automatic bit field_differs(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_beat(out_beat_t got);
    out_beat_t want;
    bit        bad;
    beat_count++;
    if (awaited_beats.size() == 0) begin
      $error("result beat with nothing awaited: ok %0d element %0d length %0d last %0d",
             got.ok, got.element, got.length, got.last);
      fail_count++;
      return;
    end
    want = awaited_beats.pop_front();
    bad  = field_differs("ok", want.ok, got.ok);
    bad |= field_differs("element", want.element, got.element);
    bad |= field_differs("length", want.length, got.length);
    bad |= field_differs("last", want.last, got.last);
    if (bad) fail_count++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      contents.delete();
      awaited_beats.delete();
    end else begin
      if (in_valid && !in_stall) apply_list_cmd(in_data);
      if (out_valid && !out_stall) check_beat(out_data);
    end
    pending = awaited_beats.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives command beats into the list store with bursts and gaps while the
// result side stalls on its own pattern. A directed opening covers empty and
// bad-position cases and value extremes; random phases then grow the list to
// full and drain it to empty. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top
  import plsu_pkg::*;
();

  localparam int               CAPACITY     = 16;
  localparam int               DATA_WIDTH   = 32;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN  = 3'd7;
  localparam int               CYCLE_LIMIT  = 200000;
  localparam int               LONG_HOLD    = 80;
  localparam int               DRAIN_CYCLES = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      hold_req  = 1'b0;
  int        cycle_count = 0;
  int        fail_count, pending, cmd_count, beat_count, reject_count, peak_length;

  always #2 clk = ~clk;

  positional_list_store_unit #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  list_beat_checker #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .cmd_count   (cmd_count),
    .beat_count  (beat_count),
    .reject_count(reject_count),
    .peak_length (peak_length)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[positional_list_store_unit] ERROR");
      $finish;
    end
  end

  // Receiver: phases of free flow, light and heavy stall, plus one long hold.
  initial begin : receiver
    int phase_left;
    int hold_left;
    int stall_pct;
    phase_left = 0;
    hold_left  = 0;
    stall_pct  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 5);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] index,
                           input logic [VAL_W-1:0] value);
    in_data  <= '{cmd: op, position: index, item_value: value};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_random(input int grow_pct);
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] index;
    logic [VAL_W-1:0] value;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 2) begin
      op = CMD_UNKNOWN;
    end else if (roll < 12) begin
      op = CMD_DUMP;
    end else if (roll < 12 + grow_pct * 88 / 100) begin
      case ($urandom_range(2))
        0:       op = CMD_INSERT_AT;
        1:       op = CMD_PUSH_FRONT;
        default: op = CMD_PUSH_BACK;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       op = CMD_DELETE_AT;
        1:       op = CMD_POP_FRONT;
        default: op = CMD_POP_BACK;
      endcase
    end
    case ($urandom_range(9))
      0:       index = POS_W'($urandom);
      1, 2:    index = POS_W'($urandom_range(16));
      default: index = POS_W'($urandom_range(8));
    endcase
    case ($urandom_range(7))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = '1;
      3:       value = '0;
      default: value = $urandom;
    endcase
    send_beat(op, index, value);
  endtask

  task automatic run_phase(input int items, input int grow_pct);
    int burst;
    while (items > 0) begin
      burst = $urandom_range(12, 1);
      while (burst > 0 && items > 0) begin
        send_random(grow_pct);
        burst--;
        items--;
      end
      if ($urandom_range(3) != 0) idle_for($urandom_range(6, 1));
    end
  endtask

  task automatic wait_for_drain();
    idle_for(1);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list: every removal and the dump are rejected
    send_beat(CMD_DUMP,       5'd0,  32'h0);
    send_beat(CMD_POP_FRONT,  5'd0,  32'h0);
    send_beat(CMD_POP_BACK,   5'd0,  32'h0);
    send_beat(CMD_DELETE_AT,  5'd0,  32'h0);
    send_beat(CMD_INSERT_AT,  5'd1,  32'h1234_5678);
    send_beat(CMD_UNKNOWN,    5'd0,  32'hffff_ffff);
    // build a short list with extreme values
    send_beat(CMD_INSERT_AT,  5'd0,  32'h8000_0000);
    send_beat(CMD_PUSH_BACK,  5'd0,  32'h7fff_ffff);
    send_beat(CMD_PUSH_FRONT, 5'd0,  32'hffff_ffff);
    send_beat(CMD_INSERT_AT,  5'd3,  32'h0);
    send_beat(CMD_INSERT_AT,  5'd2,  32'h5555_5555);
    send_beat(CMD_INSERT_AT,  5'd31, 32'haaaa_aaaa);
    send_beat(CMD_DUMP,       5'd0,  32'h0);
    // removals at the ends and in the middle
    send_beat(CMD_DELETE_AT,  5'd31, 32'h0);
    send_beat(CMD_DELETE_AT,  5'd4,  32'h0);
    send_beat(CMD_DELETE_AT,  5'd1,  32'h0);
    send_beat(CMD_POP_FRONT,  5'd0,  32'h0);
    send_beat(CMD_POP_BACK,   5'd0,  32'h0);
    send_beat(CMD_DUMP,       5'd0,  32'h0);
    send_beat(CMD_PUSH_BACK,  5'd0,  32'haaaa_aaaa);
    send_beat(CMD_DELETE_AT,  5'd2,  32'h0);
    send_beat(CMD_DUMP,       5'd0,  32'h0);

    run_phase(40, 80);
    run_phase(40, 50);

    // hold the result side off while beats keep coming, so the input stalls
    hold_req = 1'b1;
    repeat (40) send_random(85);

    run_phase(50, 15);
    wait_for_drain();
    run_phase(60, 90);
    run_phase(60, 10);
    run_phase(50, 50);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d commands giving %0d result beats; %0d were rejected, peak length %0d.",
             cmd_count, beat_count, reject_count, peak_length);
    if (fail_count == 0) begin
      $display("[positional_list_store_unit] OK");
    end else begin
      $display("[positional_list_store_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> positional_list_store_unit.f
+incdir+sv
sv/plsu_pkg.sv
sv/plsu_cell.sv
sv/positional_list_store_unit.sv
bench/list_beat_checker.sv
bench/tb_top.sv
